/* rtl/sliding_window_kth_smallest_2d_assert.svh */
// Assertion macros shared by the rank-order filter checker.
// No dependencies.
`ifndef SLIDING_WINDOW_KTH_SMALLEST_2D_ASSERT_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_2D_ASSERT_SVH
`define SWK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SWK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/swk_pkg.sv */
// Types and constants of the rank-order filter.
// No dependencies.
package swk_pkg;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W = 9;
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_ROWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RANK = 3'd4;

   typedef struct packed {
      logic start;     // latch sample, write store, decide window
      logic clear;     // clear best list
      logic read;      // issue store read at scan position
      logic insert;    // insert read data into best list
      logic advance;   // advance scan position
      logic finish;    // load result register
   } cmd_type;

   typedef struct packed {
      logic window_done; // sample completes a window with valid rank
      logic window_any;  // sample completes a window
      logic scan_last;   // scan position is last of window
   } stat_type;
endpackage

/* rtl/swk_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
module swk_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/swk_ctrl.sv */
// Controller state machine of the rank-order filter.
// Depends on swk_pkg.
module swk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              csr_ready,
   input  swk_pkg::stat_type stat,
   output swk_pkg::cmd_type  cmd
);
   import swk_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_FIN   = 5'b00100,
      ST_INS   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (stat.window_done) begin
               cmd.clear = 1'b1;
               cmd.read = 1'b1;
               last_in = stat.scan_last;
               cmd.advance = 1'b1;
               state_in = ST_INS;
            end else if (stat.window_any) begin
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INS: begin
            cmd.insert = 1'b1;
            if (last_ff) begin
               state_in = ST_FIN;
            end else begin
               cmd.read = 1'b1;
               cmd.advance = 1'b1;
               last_in = stat.scan_last;
               state_in = ST_INS;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end
endmodule

/* rtl/swk_dp.sv */
// Datapath of the rank-order filter: registers, positions, store, best list.
// Depends on swk_pkg and swk_ram.
module swk_dp #(
   parameter int unsigned MAX_ROWS = 512,
   parameter int unsigned MAX_COLS = 512,
   parameter int unsigned MAX_WIN_ROWS = 16,
   parameter int unsigned MAX_WIN_COLS = 16,
   parameter int unsigned MAX_RANK = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [swk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [9:0]              csr_data,
   input  logic [31:0]             req_sample_value,
   input  swk_pkg::cmd_type        cmd,
   output swk_pkg::stat_type       stat,
   output logic [31:0]             rsp_kth_value,
   output logic [8:0]              rsp_window_top,
   output logic [8:0]              rsp_window_left,
   output logic                    rsp_row_end,
   output logic                    rsp_frame_end,
   output logic                    rsp_short_window
);
   import swk_pkg::*;

   localparam int unsigned RW = $clog2(MAX_ROWS + 1);
   localparam int unsigned CW = $clog2(MAX_COLS + 1);
   localparam int unsigned CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned WRW = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
   localparam int unsigned DEPTH = MAX_WIN_ROWS * MAX_COLS;
   localparam int unsigned AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
   localparam int unsigned KW = $clog2(MAX_RANK + 1);
   localparam int unsigned KIW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int unsigned HW = $clog2(MAX_WIN_ROWS + 1);
   localparam int unsigned WW = $clog2(MAX_WIN_COLS + 1);
   localparam int unsigned AREA_W = HW + WW;

   logic [9:0] frows_ff, fcols_ff;
   logic [4:0] wrows_ff, wcols_ff, rank_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] rows, cur_r;
   logic [CW-1:0] cols, cur_c;
   logic [HW-1:0] wh;
   logic [WW-1:0] ww;
   logic [RW-1:0] r_ff;
   logic [CW-1:0] c_ff;
   logic [CW-1:0] left_ff;
   logic [RW-1:0] sy_ff;
   logic [CW-1:0] sx_ff;
   logic win_any, rank_ok;
   logic [DATA_W-1:0] best_ff [MAX_RANK];
   logic [KW-1:0] held_ff;
   logic [DATA_W-1:0] rd_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   function automatic logic [15:0] clampv(input logic [15:0] v, input logic [15:0] hi);
      logic [15:0] o;
      o = v;
      if (v == 16'd0) o = 16'd1;
      else if (v > hi) o = hi;
      return o;
   endfunction

   always_comb begin
      logic [15:0] t;
      t = clampv({6'd0, frows_ff}, 16'(MAX_ROWS));
      rows = RW'(t);
      t = clampv({6'd0, fcols_ff}, 16'(MAX_COLS));
      cols = CW'(t);
      t = clampv({11'd0, wrows_ff}, 16'(MAX_WIN_ROWS));
      wh = HW'(t);
      t = clampv({11'd0, wcols_ff}, 16'(MAX_WIN_COLS));
      ww = WW'(t);
   end

   assign cur_r = (row_ff >= rows) ? '0 : row_ff;
   assign cur_c = (col_ff >= cols) ? '0 : col_ff;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] y, input logic [CW-1:0] x);
      logic [WRW-1:0] ym;
      ym = WRW'(y % MAX_WIN_ROWS);
      return AW'(ym * MAX_COLS + CAW'(x));
   endfunction

   always_comb begin
      logic [AREA_W-1:0] area;
      area = AREA_W'(wh) * AREA_W'(ww);
      win_any = ((32'(r_ff) + 1) >= 32'(wh)) && ((32'(c_ff) + 1) >= 32'(ww))
         && (32'(wh) <= 32'(rows)) && (32'(ww) <= 32'(cols));
      rank_ok = (rank_ff != 5'd0) && (32'(rank_ff) <= MAX_RANK)
         && (32'(rank_ff) <= 32'(area));
   end

   assign stat.window_any = win_any;
   assign stat.window_done = win_any && rank_ok;
   assign stat.scan_last = cmd.start ? 1'b0 :
      (cmd.clear ? ((wh == HW'(1)) && (ww == WW'(1)))
                 : ((sy_ff == r_ff) && (sx_ff == c_ff)));

   assign wr_en = cmd.start;
   assign wr_addr = addr_of(cur_r, cur_c);
   assign rd_addr = cmd.clear ? addr_of(RW'(32'(r_ff) + 1 - 32'(wh)),
                                        CW'(32'(c_ff) + 1 - 32'(ww)))
                              : addr_of(sy_ff, sx_ff);

   swk_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_sample_value),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.start) begin
         if (cur_c + 1'b1 >= cols) begin
            col_in = '0;
            row_in = (cur_r + 1'b1 >= rows) ? '0 : cur_r + 1'b1;
         end else begin
            col_in = cur_c + 1'b1;
            row_in = cur_r;
         end
      end
      if (csr_we) begin
         row_in = '0;
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frows_ff <= 10'd1;
         fcols_ff <= 10'd1;
         wrows_ff <= 5'd1;
         wcols_ff <= 5'd1;
         rank_ff <= 5'd1;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_ROWS: frows_ff <= csr_data;
               REG_FRAME_COLS: fcols_ff <= csr_data;
               REG_WINDOW_ROWS: wrows_ff <= csr_data[4:0];
               REG_WINDOW_COLS: wcols_ff <= csr_data[4:0];
               REG_RANK: rank_ff <= csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

   // scan position: first read issued at (top,left) with clear
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         r_ff <= cur_r;
         c_ff <= cur_c;
      end
      if (cmd.clear) begin
         left_ff <= CW'(32'(c_ff) + 1 - 32'(ww));
         if (ww == 1) begin
            sy_ff <= RW'(32'(r_ff) + 2 - 32'(wh));
            sx_ff <= CW'(32'(c_ff) + 1 - 32'(ww));
         end else begin
            sy_ff <= RW'(32'(r_ff) + 1 - 32'(wh));
            sx_ff <= CW'(32'(c_ff) + 2 - 32'(ww));
         end
      end else if (cmd.advance) begin
         if (sx_ff == c_ff) begin
            sx_ff <= left_ff;
            sy_ff <= sy_ff + 1'b1;
         end else begin
            sx_ff <= sx_ff + 1'b1;
         end
      end
   end

   // best list: sorted insertion, one value per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (cmd.clear) begin
         held_ff <= '0;
      end else if (cmd.insert && 32'(held_ff) < 32'(rank_ff)) begin
         held_ff <= held_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < MAX_RANK; i++) begin
            logic gt_here, gt_prev;
            gt_here = (i < 32'(held_ff)) &&
               ($signed(best_ff[i]) > $signed(rd_data));
            gt_prev = (i > 0) && (i - 1 < 32'(held_ff)) &&
               ($signed(best_ff[(i > 0) ? i - 1 : 0]) > $signed(rd_data));
            if (gt_prev) begin
               best_ff[i] <= best_ff[(i > 0) ? i - 1 : 0];
            end else if (gt_here || i == 32'(held_ff)) begin
               best_ff[i] <= rd_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_window_top <= 9'(32'(r_ff) + 1 - 32'(wh));
         rsp_window_left <= 9'(32'(c_ff) + 1 - 32'(ww));
         rsp_row_end <= (32'(c_ff) + 1 == 32'(cols));
         rsp_frame_end <= (32'(c_ff) + 1 == 32'(cols)) && (32'(r_ff) + 1 == 32'(rows));
         rsp_short_window <= !rank_ok;
         rsp_kth_value <= rank_ok ? best_ff[KIW'(rank_ff - 5'd1)] : '0;
      end
   end
endmodule

/* rtl/sliding_window_kth_smallest_2d.sv */
// Rank-order filter top level: controller plus datapath.
// Sequence: a short window's result is loaded in the start state; a full one's after
// one insert state per window sample and then the finish state; no window, no result.
// A new request is taken only back in idle, so not before the last response is taken
// on rsp; the window scan reads one store sample a cycle.
// Reset: synchronous; registers to 1, position to 0, store left as is.
module sliding_window_kth_smallest_2d #(
   parameter int unsigned MAX_ROWS = 512,
   parameter int unsigned MAX_COLS = 512,
   parameter int unsigned MAX_WIN_ROWS = 16,
   parameter int unsigned MAX_WIN_COLS = 16,
   parameter int unsigned MAX_RANK = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_kth_value,
   output logic [8:0]  rsp_window_top,
   output logic [8:0]  rsp_window_left,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   output logic        rsp_short_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [swk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [9:0]  csr_data
);
   import swk_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   swk_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .csr_ready(csr_ready),
      .stat(stat), .cmd(cmd)
   );

   swk_dp #(
      .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_WIN_ROWS(MAX_WIN_ROWS),
      .MAX_WIN_COLS(MAX_WIN_COLS), .MAX_RANK(MAX_RANK)
   ) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_valid && csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_sample_value(req_sample_value), .cmd(cmd), .stat(stat),
      .rsp_kth_value(rsp_kth_value), .rsp_window_top(rsp_window_top),
      .rsp_window_left(rsp_window_left), .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end), .rsp_short_window(rsp_short_window)
   );
endmodule

/* rtl/swk_checker.sv */
// Port-level checker for the rank-order filter, bound to the top level.
// Depends on sliding_window_kth_smallest_2d_assert.svh.
`include "sliding_window_kth_smallest_2d_assert.svh"
module swk_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_row_end,
   input logic       rsp_frame_end,
   input logic       rsp_short_window,
   input logic [31:0] rsp_kth_value,
   input logic       csr_ready
);
   `SWK_ASSERT_IMP(a_frame_row, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end)
   `SWK_ASSERT_IMP(a_short_zero, clock, reset, rsp_valid && rsp_short_window,
      rsp_kth_value == 32'd0)
   `SWK_ASSERT_IMP(a_no_req_busy, clock, reset, rsp_valid, !req_ready)
   `SWK_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SWK_ASSERT_IMP(a_csr_idle, clock, reset, csr_ready, req_ready && !req_valid)
endmodule

bind sliding_window_kth_smallest_2d swk_checker u_swk_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_row_end(rsp_row_end),
   .rsp_frame_end(rsp_frame_end), .rsp_short_window(rsp_short_window),
   .rsp_kth_value(rsp_kth_value), .csr_ready(csr_ready)
);
